// File: rtl/pcc_pkg.sv
// ---------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the polygon convexity check unit.
// ---------------------------------------------------------------------------
package pcc_pkg;

   // turns examined per vertex: the running turn and the two closing turns
   localparam int TURNS          = 3;
   localparam int DIFFS_PER_TURN = 4;

   // queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // sign of one cross product
   typedef enum logic [1:0] {
      TURN_NONE = 2'b00,
      TURN_POS  = 2'b01,
      TURN_NEG  = 2'b10
   } turn_type;

   // control part of one queued task
   typedef struct packed {
      logic [TURNS-1:0] turn_vld;
      logic             clear;
      logic             last;
   } task_ctl_type;

endpackage

// File: rtl/pcc_front.sv
// ---------------------------------------------------------------------------
// pcc_front
// Accepts vertices, keeps the vertex history and turns each vertex into a
// task: edge differences of the triples to test and the duplicate checks.
// ---------------------------------------------------------------------------
module pcc_front #(
   parameter int COORD_WIDTH = 31
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0]          req_vertex_y,
   input  logic                                   req_last_vertex,
   input  logic                                   queue_full,
   output logic                                   task_push,
   output pcc_pkg::task_ctl_type                  task_ctl,
   output logic [pcc_pkg::TURNS-1:0][pcc_pkg::DIFFS_PER_TURN-1:0][COORD_WIDTH:0] task_diff
);
   import pcc_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + 1;

   localparam logic [1:0] PTS_NONE = 2'd0;
   localparam logic [1:0] PTS_ONE  = 2'd1;
   localparam logic [1:0] PTS_TWO  = 2'd2;
   localparam logic [1:0] PTS_MANY = 2'd3;

   logic [1:0]   points_ff, points_in;
   logic [W-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic [W-1:0] older_x_ff, older_y_ff, newer_x_ff, newer_y_ff;
   logic [W-1:0] first_x_in, first_y_in, second_x_in, second_y_in;
   logic [W-1:0] older_x_in, older_y_in, newer_x_in, newer_y_in;
   logic [W-1:0] cur_x, cur_y;

   // edge vectors (n - o) and (c - o), sign-extended by one bit
   function automatic logic [DIFFS_PER_TURN-1:0][DW-1:0] triple_diff(
      input logic [W-1:0] ox, input logic [W-1:0] oy,
      input logic [W-1:0] nx, input logic [W-1:0] ny,
      input logic [W-1:0] cx, input logic [W-1:0] cy);
      logic [DIFFS_PER_TURN-1:0][DW-1:0] d;
      d[0] = {nx[W-1], nx} - {ox[W-1], ox};
      d[1] = {ny[W-1], ny} - {oy[W-1], oy};
      d[2] = {cx[W-1], cx} - {ox[W-1], ox};
      d[3] = {cy[W-1], cy} - {oy[W-1], oy};
      return d;
   endfunction

   assign cur_x     = req_vertex_x;
   assign cur_y     = req_vertex_y;
   assign req_stall = queue_full;
   assign task_push = req_valid && !queue_full;

   // classify the vertex and work out the next history
   always_comb begin
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      second_x_in = second_x_ff;
      second_y_in = second_y_ff;
      older_x_in  = older_x_ff;
      older_y_in  = older_y_ff;
      newer_x_in  = newer_x_ff;
      newer_y_in  = newer_y_ff;
      points_in   = points_ff;
      task_ctl    = '0;
      task_diff   = '0;
      task_ctl.last = req_last_vertex;

      case (points_ff)
         PTS_NONE: begin
            first_x_in = cur_x;
            first_y_in = cur_y;
            newer_x_in = cur_x;
            newer_y_in = cur_y;
            points_in  = PTS_ONE;
         end
         PTS_ONE: begin
            second_x_in    = cur_x;
            second_y_in    = cur_y;
            task_ctl.clear = (cur_x == first_x_ff) && (cur_y == first_y_ff);
            older_x_in     = first_x_ff;
            older_y_in     = first_y_ff;
            newer_x_in     = cur_x;
            newer_y_in     = cur_y;
            points_in      = PTS_TWO;
         end
         default: begin
            task_ctl.clear       = (cur_x == newer_x_ff) && (cur_y == newer_y_ff);
            task_ctl.turn_vld[0] = 1'b1;
            task_diff[0] = triple_diff(older_x_ff, older_y_ff, newer_x_ff, newer_y_ff,
                                       cur_x, cur_y);
            older_x_in = newer_x_ff;
            older_y_in = newer_y_ff;
            newer_x_in = cur_x;
            newer_y_in = cur_y;
            points_in  = PTS_MANY;
         end
      endcase

      // closing turns back to the first and second vertices
      if (req_last_vertex && (points_ff inside {PTS_TWO, PTS_MANY})) begin
         task_ctl.turn_vld[1] = 1'b1;
         task_ctl.turn_vld[2] = 1'b1;
         task_diff[1] = triple_diff(newer_x_ff, newer_y_ff, cur_x, cur_y,
                                    first_x_ff, first_y_ff);
         task_diff[2] = triple_diff(cur_x, cur_y, first_x_ff, first_y_ff,
                                    second_x_ff, second_y_ff);
         if ((first_x_ff == cur_x) && (first_y_ff == cur_y)) begin
            task_ctl.clear = 1'b1;
         end
         if ((second_x_ff == first_x_ff) && (second_y_ff == first_y_ff)) begin
            task_ctl.clear = 1'b1;
         end
      end

      if (req_last_vertex) begin
         points_in = PTS_NONE;
      end
   end

   // vertex count
   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= PTS_NONE;
      end else if (task_push) begin
         points_ff <= points_in;
      end
   end

   // vertex history
   always_ff @(posedge clock) begin
      if (task_push) begin
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         second_x_ff <= second_x_in;
         second_y_ff <= second_y_in;
         older_x_ff  <= older_x_in;
         older_y_ff  <= older_y_in;
         newer_x_ff  <= newer_x_in;
         newer_y_ff  <= newer_y_in;
      end
   end

endmodule

// File: rtl/pcc_queue.sv
// ---------------------------------------------------------------------------
// pcc_queue
// Short first-in first-out queue of tasks between the front and the back.
// ---------------------------------------------------------------------------
module pcc_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);
   import pcc_pkg::*;

   localparam logic [QUEUE_PTR_W:0] DEPTH_COUNT = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

   logic [DATA_W-1:0]      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == DEPTH_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/pcc_back.sv
// ---------------------------------------------------------------------------
// pcc_back
// Evaluates the queued turns: cross products, their signs, then the running
// turn sign and convex flag, and holds the result for the consumer.
// ---------------------------------------------------------------------------
module pcc_back #(
   parameter int COORD_WIDTH = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  task_valid,
   output logic                  task_pop,
   input  pcc_pkg::task_ctl_type task_ctl,
   input  logic [pcc_pkg::TURNS-1:0][pcc_pkg::DIFFS_PER_TURN-1:0][COORD_WIDTH:0] task_diff,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_convex
);
   import pcc_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic                 advance;
   logic                 a_valid_ff, b_valid_ff;
   task_ctl_type         a_ctl_ff, b_ctl_ff;
   logic signed [PW-1:0] prod_p_ff [TURNS];
   logic signed [PW-1:0] prod_q_ff [TURNS];
   logic signed [PW-1:0] prod_p_in [TURNS];
   logic signed [PW-1:0] prod_q_in [TURNS];
   turn_type             sign_ff [TURNS];
   turn_type             sign_in [TURNS];
   logic signed [PW:0]   cross_diff [TURNS];
   turn_type             turn_sign_ff, turn_sign_in;
   logic                 convex_ff, convex_in;
   logic                 rsp_valid_ff, rsp_is_convex_ff;

   function automatic logic opposite(input turn_type a, input turn_type b);
      return ((a == TURN_POS) && (b == TURN_NEG)) || ((a == TURN_NEG) && (b == TURN_POS));
   endfunction

   // the whole back moves unless a held result is stalled
   assign advance       = !rsp_valid_ff || !rsp_stall;
   assign task_pop      = task_valid && advance;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_convex = rsp_is_convex_ff;

   // stage a: the two products of each cross product
   always_comb begin
      for (int t = 0; t < TURNS; t++) begin
         prod_p_in[t] = $signed(task_diff[t][0]) * $signed(task_diff[t][3]);
         prod_q_in[t] = $signed(task_diff[t][1]) * $signed(task_diff[t][2]);
      end
   end

   // stage b: exact sign of p - q
   always_comb begin
      for (int t = 0; t < TURNS; t++) begin
         cross_diff[t] = {prod_p_ff[t][PW-1], prod_p_ff[t]}
                       - {prod_q_ff[t][PW-1], prod_q_ff[t]};
         if (cross_diff[t][PW]) begin
            sign_in[t] = TURN_NEG;
         end else if (cross_diff[t] != '0) begin
            sign_in[t] = TURN_POS;
         end else begin
            sign_in[t] = TURN_NONE;
         end
      end
   end

   // stage c: fold the turns into the polygon state
   always_comb begin
      turn_sign_in = turn_sign_ff;
      convex_in    = convex_ff && !b_ctl_ff.clear;
      if (b_ctl_ff.turn_vld[0]) begin
         if (opposite(turn_sign_in, sign_ff[0])) begin
            convex_in = 1'b0;
         end
         if ((sign_ff[0] != TURN_NONE) && (turn_sign_in == TURN_NONE)) begin
            turn_sign_in = sign_ff[0];
         end
      end
      if (b_ctl_ff.turn_vld[1] && opposite(turn_sign_in, sign_ff[1])) begin
         convex_in = 1'b0;
      end
      if (b_ctl_ff.turn_vld[2] && opposite(turn_sign_in, sign_ff[2])) begin
         convex_in = 1'b0;
      end
   end

   // stage valids, polygon state and result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         turn_sign_ff <= TURN_NONE;
         convex_ff    <= 1'b1;
      end else if (advance) begin
         a_valid_ff   <= task_valid;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff && b_ctl_ff.last;
         if (b_valid_ff) begin
            if (b_ctl_ff.last) begin
               turn_sign_ff <= TURN_NONE;
               convex_ff    <= 1'b1;
            end else begin
               turn_sign_ff <= turn_sign_in;
               convex_ff    <= convex_in;
            end
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         if (task_valid) begin
            a_ctl_ff <= task_ctl;
            for (int t = 0; t < TURNS; t++) begin
               prod_p_ff[t] <= prod_p_in[t];
               prod_q_ff[t] <= prod_q_in[t];
            end
         end
         if (a_valid_ff) begin
            b_ctl_ff <= a_ctl_ff;
            for (int t = 0; t < TURNS; t++) begin
               sign_ff[t] <= sign_in[t];
            end
         end
         if (b_valid_ff && b_ctl_ff.last) begin
            rsp_is_convex_ff <= convex_in;
         end
      end
   end

endmodule

// File: rtl/polygon_convexity_check_unit.sv
// ---------------------------------------------------------------------------
// polygon_convexity_check_unit
// Streaming convexity test of a polygon given one vertex per transaction.
// ---------------------------------------------------------------------------
// Vertices arrive one per request transaction, the last one flagged by
// req_last_vertex; one response transaction then carries rsp_is_convex. The
// unit takes a vertex every clock cycle while req_stall is low: the front
// keeps the vertex history and forms edge differences, a four-entry queue
// decouples it from the back, which runs the running turn and both closing
// turns through six parallel multipliers, a sign stage and a fold stage. A
// last vertex passes the queue, product, sign and response registers; the
// queue lets four vertices in while a response waits. Collinear vertices are
// accepted; a vertex equal to its predecessor or a last one equal to the
// first makes the polygon non-convex, else one or two vertices are convex.
module polygon_convexity_check_unit #(
   parameter int COORD_WIDTH = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_convex
);
   import pcc_pkg::*;

   localparam int DW     = COORD_WIDTH + 1;
   localparam int DIFF_W = TURNS * DIFFS_PER_TURN * DW;
   localparam int DATA_W = $bits(task_ctl_type) + DIFF_W;

   logic                                          queue_full;
   logic                                          task_push;
   task_ctl_type                                  push_ctl;
   logic [TURNS-1:0][DIFFS_PER_TURN-1:0][DW-1:0]  push_diff;
   logic                                          task_pop;
   logic                                          pop_valid;
   logic [DATA_W-1:0]                             pop_data;
   task_ctl_type                                  pop_ctl;
   logic [TURNS-1:0][DIFFS_PER_TURN-1:0][DW-1:0]  pop_diff;

   assign {pop_ctl, pop_diff} = pop_data;

   // vertex intake and classification
   pcc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .queue_full      (queue_full),
      .task_push       (task_push),
      .task_ctl        (push_ctl),
      .task_diff       (push_diff)
   );

   // task queue
   pcc_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (task_push),
      .push_data ({push_ctl, push_diff}),
      .full      (queue_full),
      .pop       (task_pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // turn evaluation and result
   pcc_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .task_valid    (pop_valid),
      .task_pop      (task_pop),
      .task_ctl      (pop_ctl),
      .task_diff     (pop_diff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_convex (rsp_is_convex)
   );

endmodule
